// ===== rtl/rgb2ycc_pkg.sv =====
package rgb2ycc_pkg;

   // Color matrix weights, 13 fractional bits, stored as magnitudes.
   // The sign of each weight is applied where the three products are summed.
   localparam logic [12:0] KY_R  = 13'd2104;
   localparam logic [12:0] KY_G  = 13'd4130;
   localparam logic [12:0] KY_B  = 13'd802;
   localparam logic [12:0] KCB_R = 13'd1214;
   localparam logic [12:0] KCB_G = 13'd2384;
   localparam logic [12:0] KCB_B = 13'd3598;
   localparam logic [12:0] KCR_R = 13'd3598;
   localparam logic [12:0] KCR_G = 13'd3013;
   localparam logic [12:0] KCR_B = 13'd585;

   // Offsets with the rounding half (4096) already folded in.
   localparam logic [22:0] OFS_Y = 23'd135168;
   localparam logic [22:0] OFS_C = 23'd1052672;

   localparam logic [7:0] CAP_Y = 8'd235;
   localparam logic [7:0] CAP_C = 8'd240;

   localparam logic [11:0] FRAME_WIDTH_RESET = 12'd640;

   // Register index of the only configuration register.
   localparam logic REG_FRAME_WIDTH = 1'b0;

   typedef logic [20:0] product_type;

   typedef struct packed {
      logic [8:0] cb;
      logic [8:0] cr;
   } pair_type;

   typedef struct packed {
      logic odd_col;
      logic odd_row;
   } pos_type;

   function automatic product_type mult8x13(input logic [7:0] a, input logic [12:0] k);
      return {13'd0, a} * {8'd0, k};
   endfunction

   function automatic logic [7:0] cap_shift(input logic [22:0] sum, input logic [7:0] cap);
      logic [9:0] v;
      v = sum[22:13];
      if (v > {2'b00, cap}) begin
         return cap;
      end
      return v[7:0];
   endfunction

endpackage

// ===== rtl/rgb2ycc_line_mem.sv =====
module rgb2ycc_line_mem
   import rgb2ycc_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pair_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pair_type          rd_data
);

   pair_type mem [DEPTH];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgb_to_ycbcr420_converter.sv =====
// Channel   Direction  Ports                                   Handshake
// req       in         req_start_of_frame, req_red/green/blue  req_valid / req_stall
// rsp       out        rsp_luma, rsp_chroma_valid, rsp_cb/cr   rsp_valid / rsp_stall
// csr       in/out     csr_psel ... csr_prdata, csr_pready     APB read/write, pready tied high
//
// One word is accepted per clock unless req_stall is high. Each word gives exactly
// one result word, valid on the rsp side once it moves into the output register.
// The color products, weighted sums with caps and the 2x2 chroma average are
// formed in one pass between the input register and the output register.
// The input register loads when it is empty or when its word moves on, so a
// stalled result holds its payload and req_stall rises only when both are full.
// Reset is synchronous and clears the valid bits, the row and column position
// and the frame width register (back to 640); the line store is not cleared.
module rgb_to_ycbcr420_converter
   import rgb2ycc_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_of_frame,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_luma,
   output logic        rsp_chroma_valid,
   output logic [7:0]  rsp_cb_average,
   output logic [7:0]  rsp_cr_average,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // The line store keeps one pair sum for every two columns of the widest row.
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W      = $clog2(MAX_WIDTH + 1);
   localparam int AW         = (COL_W > 12) ? COL_W : 12;
   localparam int TOP_INT    = (MAX_WIDTH / 2) * 2;
   localparam logic [AW-1:0] TOP_WIDTH = AW'(TOP_INT);
   localparam logic [AW-1:0] MIN_WIDTH = AW'(2);

   // ---------------------------------------------------------------------
   // Configuration port. Only one register exists and the address carries
   // just the byte offset within it, so every write lands in the frame width
   // and every read returns it.
   // ---------------------------------------------------------------------
   logic [11:0] frame_width_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {20'd0, frame_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RESET;
      end else if (csr_write) begin
         frame_width_ff <= csr_pwdata[11:0];
      end
   end

   // The even part of the programmed width, held between two and the widest
   // row the line store can take.
   logic [AW-1:0] width_even;
   logic [AW-1:0] active_width;

   assign width_even = AW'({frame_width_ff[11:1], 1'b0});

   always_comb begin
      priority if (width_even > TOP_WIDTH) begin
         active_width = TOP_WIDTH;
      end else if (width_even < MIN_WIDTH) begin
         active_width = MIN_WIDTH;
      end else begin
         active_width = width_even;
      end
   end

   // ---------------------------------------------------------------------
   // Stage enables. A register may load when it is empty or when its word
   // moves on.
   // ---------------------------------------------------------------------
   logic p1_valid_ff, rsp_valid_ff;
   logic adv1, adv2;
   logic accept;

   assign adv2      = ~rsp_valid_ff | ~rsp_stall;
   assign adv1      = ~p1_valid_ff | adv2;
   assign req_stall = ~adv1;
   assign accept    = req_valid & adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            p1_valid_ff <= req_valid;
         end
         if (adv2) begin
            rsp_valid_ff <= p1_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Raster position. The column and row parity are tracked at acceptance,
   // so the input register only carries what this pixel needs. A start of
   // frame, or a column left beyond a width that was shrunk, resets the
   // position before the pixel is placed.
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic             row_odd_ff, row_odd_in;
   logic [AW-1:0]    col_ext;
   logic [AW-1:0]    col_pre;
   logic             row_pre;
   logic [AW-1:0]    col_step;

   assign col_ext = AW'(col_ff);

   always_comb begin
      priority if (req_start_of_frame) begin
         col_pre = '0;
         row_pre = 1'b0;
      end else if (col_ext >= active_width) begin
         col_pre = '0;
         row_pre = ~row_odd_ff;
      end else begin
         col_pre = col_ext;
         row_pre = row_odd_ff;
      end
      col_step = col_pre + AW'(1);
      if (col_step >= active_width) begin
         col_in     = '0;
         row_odd_in = ~row_pre;
      end else begin
         col_in     = col_step[COL_W-1:0];
         row_odd_in = row_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_odd_ff <= 1'b0;
      end else if (accept) begin
         col_ff     <= col_in;
         row_odd_ff <= row_odd_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register.
   // ---------------------------------------------------------------------
   logic [7:0]        p1_red_ff, p1_green_ff, p1_blue_ff;
   pos_type           p1_pos_ff;
   logic [SLOT_W-1:0] p1_slot_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_red_ff         <= req_red;
         p1_green_ff       <= req_green;
         p1_blue_ff        <= req_blue;
         p1_pos_ff.odd_col <= col_pre[0];
         p1_pos_ff.odd_row <= row_pre;
         p1_slot_ff        <= col_pre[SLOT_W:1];
      end
   end

   // ---------------------------------------------------------------------
   // Weighted sums, shift and cap. All three sums stay positive for any
   // 8-bit color, so plain 23-bit wrap-around arithmetic is exact.
   // ---------------------------------------------------------------------
   logic [22:0] sum_y, sum_cb, sum_cr;
   logic [7:0]  pix_y, pix_cb, pix_cr;

   always_comb begin
      sum_y  = OFS_Y + 23'(mult8x13(p1_red_ff, KY_R))
             + 23'(mult8x13(p1_green_ff, KY_G)) + 23'(mult8x13(p1_blue_ff, KY_B));
      sum_cb = OFS_C + 23'(mult8x13(p1_blue_ff, KCB_B))
             - 23'(mult8x13(p1_red_ff, KCB_R)) - 23'(mult8x13(p1_green_ff, KCB_G));
      sum_cr = OFS_C + 23'(mult8x13(p1_red_ff, KCR_R))
             - 23'(mult8x13(p1_green_ff, KCR_G)) - 23'(mult8x13(p1_blue_ff, KCR_B));
      pix_y  = cap_shift(sum_y,  CAP_Y);
      pix_cb = cap_shift(sum_cb, CAP_C);
      pix_cr = cap_shift(sum_cr, CAP_C);
   end

   // ---------------------------------------------------------------------
   // Line store. The read is issued at acceptance, so its data sits beside
   // the pixel in the input register. The even row's write for the same
   // slot happens as that pixel leaves the input register, which is always
   // before the edge at which the odd row's reader is accepted, even at the
   // smallest width of two pixels.
   // ---------------------------------------------------------------------
   logic       p1_leaves;
   logic       line_wr_en;
   pair_type   line_rd_data;
   pair_type   line_wr_data;
   logic [7:0] held_cb_ff, held_cr_ff;
   logic       finish_block;
   logic [9:0] quad_cb, quad_cr;

   assign p1_leaves    = adv2 & p1_valid_ff;
   assign line_wr_en   = p1_leaves & p1_pos_ff.odd_col & ~p1_pos_ff.odd_row;
   assign finish_block = p1_pos_ff.odd_col & p1_pos_ff.odd_row;

   rgb2ycc_line_mem #(
      .DEPTH (LINE_DEPTH)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (p1_slot_ff),
      .wr_data (line_wr_data),
      .rd_en   (accept),
      .rd_addr (col_pre[SLOT_W:1]),
      .rd_data (line_rd_data)
   );

   // The even column's chroma is held until its odd neighbor arrives. On an
   // even row the pair sum goes into the line store; on an odd row the stored
   // pair plus this pair gives the four-sample sum, and its quarter is the
   // block average.
   always_comb begin
      line_wr_data.cb = {1'b0, held_cb_ff} + {1'b0, pix_cb};
      line_wr_data.cr = {1'b0, held_cr_ff} + {1'b0, pix_cr};
      quad_cb = {1'b0, line_rd_data.cb} + 10'(line_wr_data.cb);
      quad_cr = {1'b0, line_rd_data.cr} + 10'(line_wr_data.cr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cb_ff <= '0;
         held_cr_ff <= '0;
      end else if (p1_leaves && !p1_pos_ff.odd_col) begin
         held_cb_ff <= pix_cb;
         held_cr_ff <= pix_cr;
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic [7:0] rsp_luma_ff;
   logic       rsp_chroma_valid_ff;
   logic [7:0] rsp_cb_ff, rsp_cr_ff;

   always_ff @(posedge clock) begin
      if (p1_leaves) begin
         rsp_luma_ff         <= pix_y;
         rsp_chroma_valid_ff <= finish_block;
         rsp_cb_ff           <= finish_block ? quad_cb[9:2] : 8'd0;
         rsp_cr_ff           <= finish_block ? quad_cr[9:2] : 8'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma         = rsp_luma_ff;
   assign rsp_chroma_valid = rsp_chroma_valid_ff;
   assign rsp_cb_average   = rsp_cb_ff;
   assign rsp_cr_average   = rsp_cr_ff;

endmodule

// ===== tb/sv/ycc420_checker.sv =====
`timescale 1ns / 100ps

module ycc420_checker
   import rgb2ycc_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_start_of_frame,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_luma,
   input  logic        rsp_chroma_valid,
   input  logic [7:0]  rsp_cb_average,
   input  logic [7:0]  rsp_cr_average,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,

   output int          mismatch_count,
   output int          outstanding
);

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam logic [1:0] FRAME_WIDTH_ADDR = 2'(4 * int'(REG_FRAME_WIDTH));
   localparam int REPORT_LIMIT = 10;

   // Signed BT.601 weights with 13 fractional bits.
   localparam int Y_R  = 2104;
   localparam int Y_G  = 4130;
   localparam int Y_B  = 802;
   localparam int CB_R = -1214;
   localparam int CB_G = -2384;
   localparam int CB_B = 3598;
   localparam int CR_R = 3598;
   localparam int CR_G = -3013;
   localparam int CR_B = -585;
   localparam int ROUND_HALF = 4096;
   localparam int LUMA_OFFSET = 131072;
   localparam int CHROMA_OFFSET = 1048576;
   localparam int LUMA_CAP = 235;
   localparam int CHROMA_CAP = 240;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb_average;
      logic [7:0] cr_average;
   } ycc_word_type;

   ycc_word_type ycc_queue[$];
   logic [11:0]  width_reg;
   int           column;
   logic         odd_row;
   logic [7:0]   held_cb;
   logic [7:0]   held_cr;
   logic [8:0]   cb_pairs [LINE_DEPTH];
   logic [8:0]   cr_pairs [LINE_DEPTH];
   int           errors;

   function automatic int line_width();
      int w;
      w = int'(width_reg & 12'hFFE);
      if (w > (MAX_WIDTH & ~1)) w = MAX_WIDTH & ~1;
      if (w < 2) w = 2;
      return w;
   endfunction

   function automatic logic [7:0] scale_and_cap(input int sum, input int cap);
      int v;
      v = (sum < 0) ? 0 : sum >>> 13;
      return 8'((v > cap) ? cap : v);
   endfunction

   // Converts one pixel and advances the row and column position.
   function automatic ycc_word_type convert_pixel(input logic sof, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b);
      ycc_word_type w;
      int           width;
      int           slot;
      logic [7:0]   cb;
      logic [7:0]   cr;
      width = line_width();
      if (sof) begin
         column = 0;
         odd_row = 1'b0;
      end else if (column >= width) begin
         column = 0;
         odd_row = ~odd_row;
      end
      w = '0;
      w.luma = scale_and_cap(Y_R * int'(r) + Y_G * int'(g) + Y_B * int'(b)
                             + ROUND_HALF + LUMA_OFFSET, LUMA_CAP);
      cb = scale_and_cap(CB_R * int'(r) + CB_G * int'(g) + CB_B * int'(b)
                         + ROUND_HALF + CHROMA_OFFSET, CHROMA_CAP);
      cr = scale_and_cap(CR_R * int'(r) + CR_G * int'(g) + CR_B * int'(b)
                         + ROUND_HALF + CHROMA_OFFSET, CHROMA_CAP);
      slot = column >> 1;
      if (slot >= LINE_DEPTH) slot = LINE_DEPTH - 1;
      if (column % 2 == 0) begin
         held_cb = cb;
         held_cr = cr;
      end else if (!odd_row) begin
         cb_pairs[slot] = 9'(int'(held_cb) + int'(cb));
         cr_pairs[slot] = 9'(int'(held_cr) + int'(cr));
      end else begin
         w.chroma_valid = 1'b1;
         w.cb_average = 8'((int'(cb_pairs[slot]) + int'(held_cb) + int'(cb)) >> 2);
         w.cr_average = 8'((int'(cr_pairs[slot]) + int'(held_cr) + int'(cr)) >> 2);
      end
      if (column + 1 >= width) begin
         column = 0;
         odd_row = ~odd_row;
      end else begin
         column++;
      end
      return w;
   endfunction

   always @(posedge clock) begin
      ycc_word_type want;
      ycc_word_type got;
      if (reset) begin
         ycc_queue.delete();
         width_reg = FRAME_WIDTH_RESET;
         column = 0;
         odd_row = 1'b0;
         held_cb = '0;
         held_cr = '0;
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == FRAME_WIDTH_ADDR) begin
            width_reg = csr_pwdata[11:0];
         end
         if (req_valid && !req_stall) begin
            ycc_queue.push_back(convert_pixel(req_start_of_frame, req_red,
                                              req_green, req_blue));
         end
         if (rsp_valid && !rsp_stall) begin
            got.luma = rsp_luma;
            got.chroma_valid = rsp_chroma_valid;
            got.cb_average = rsp_cb_average;
            got.cr_average = rsp_cr_average;
            if (ycc_queue.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result word: luma=%0d cv=%0b cb=%0d cr=%0d",
                           $time, got.luma, got.chroma_valid, got.cb_average,
                           got.cr_average);
               end
            end else begin
               want = ycc_queue.pop_front();
               if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid
                   || got.cb_average !== want.cb_average
                   || got.cr_average !== want.cr_average) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $write("%0t: mismatch: expected luma=%0d cv=%0b cb=%0d cr=%0d,",
                            $time, want.luma, want.chroma_valid, want.cb_average,
                            want.cr_average);
                     $display(" got luma=%0d cv=%0b cb=%0d cr=%0d", got.luma,
                              got.chroma_valid, got.cb_average, got.cr_average);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= ycc_queue.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import rgb2ycc_pkg::*;
();

   localparam int MAX_WIDTH = 2048;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam logic [1:0] FRAME_WIDTH_ADDR = 2'(4 * int'(REG_FRAME_WIDTH));

   // The directed frame runs at width 2, so every four words close a 2x2 block.
   // It covers black and white, the primaries and their mixes, a block of
   // pure blue for the top of Cb, and start-of-frame markers both at a row
   // start and in the middle of an odd row.
   localparam int DIRECTED_COUNT = 20;
   localparam logic [23:0] DIRECTED_RGB [DIRECTED_COUNT] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF,
      24'h00FF00, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
      24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF,
      24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFF0000,
      24'hFF0000, 24'hFF0000, 24'hFF0000, 24'h808080
   };
   localparam logic [DIRECTED_COUNT-1:0] DIRECTED_SOF = 20'b0000_1001_0000_0000_0001;

   // Widths written before each random phase. Out-of-range and odd values
   // check the saturation and the dropped low bit; the list also makes the
   // width shrink below the current column now and then.
   localparam int PHASE_COUNT = 12;
   localparam logic [11:0] PHASE_WIDTHS [PHASE_COUNT] = '{
      12'd4095, 12'd0, 12'd6, 12'd1, 12'd24, 12'd33,
      12'd640, 12'd3, 12'd12, 12'd4094, 12'd10, 12'd7
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_of_frame = 1'b0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_luma;
   logic        rsp_chroma_valid;
   logic [7:0]  rsp_cb_average;
   logic [7:0]  rsp_cr_average;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          mismatch_count;
   int          outstanding;

   // When set, neither the sender nor the receiver inserts idle cycles.
   logic        steady = 1'b0;

   // Stimulus-side view of the raster position. It exists only so that no
   // odd row ever reads a line-store entry that no even row has written;
   // such a word gets a start-of-frame marker instead.
   logic [11:0] width_setting;
   int          at_column;
   logic        at_odd_row;
   logic        line_filled [LINE_DEPTH];

   rgb_to_ycbcr420_converter #(
      .MAX_WIDTH(MAX_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_of_frame(req_start_of_frame),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_luma(rsp_luma),
      .rsp_chroma_valid(rsp_chroma_valid),
      .rsp_cb_average(rsp_cb_average),
      .rsp_cr_average(rsp_cr_average),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   ycc420_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_of_frame(req_start_of_frame),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_luma(rsp_luma),
      .rsp_chroma_valid(rsp_chroma_valid),
      .rsp_cb_average(rsp_cb_average),
      .rsp_cr_average(rsp_cr_average),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_pready(csr_pready),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Unless steady is set, the receiver stalls with a chance of roughly 36 in a hundred.
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 36);
   end

   // A hard limit on the run in case the block hangs.
   initial begin
      #5_000_000;
      $display("** rgb_to_ycbcr420_converter: FAILED **");
      $finish;
   end

   function automatic int active_width();
      int w;
      w = int'(width_setting & 12'hFFE);
      if (w > (MAX_WIDTH & ~1)) w = MAX_WIDTH & ~1;
      if (w < 2) w = 2;
      return w;
   endfunction

   // Biased toward the two extremes so that caps and floors are hit often.
   function automatic logic [7:0] pick_component();
      unique case ($urandom_range(7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom());
         end
      endcase
   endfunction

   // Advances the raster position for one word and may force a start of
   // frame when the word would complete a block over an unwritten entry.
   task automatic track_position(inout logic sof);
      int w;
      w = active_width();
      if (!sof && at_column >= w) begin
         at_column = 0;
         at_odd_row = ~at_odd_row;
      end
      if (!sof && at_odd_row && (at_column % 2 == 1) && !line_filled[at_column >> 1]) begin
         sof = 1'b1;
      end
      if (sof) begin
         at_column = 0;
         at_odd_row = 1'b0;
      end
      if (!at_odd_row && (at_column % 2 == 1)) begin
         line_filled[at_column >> 1] = 1'b1;
      end
      if (at_column + 1 >= w) begin
         at_column = 0;
         at_odd_row = ~at_odd_row;
      end else begin
         at_column++;
      end
   endtask

   // Presents one pixel word, possibly after a few idle cycles, and returns
   // right after the edge at which it was accepted. Valid stays high so the
   // next word can follow back to back.
   task automatic send_pixel(input logic sof, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
      logic marker;
      marker = sof;
      track_position(marker);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_of_frame <= marker;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Writes the frame width once the block has drained. Every word yields a
   // result, so an empty expectation store means the pipeline is empty; the
   // extra cycles are only margin. The upper data bits are random because
   // the register keeps only the low twelve.
   task automatic write_frame_width(input logic [11:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= FRAME_WIDTH_ADDR;
      csr_pwdata <= {20'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      width_setting = value;
   endtask

   initial begin
      int count;
      int drain;
      width_setting = FRAME_WIDTH_RESET;
      at_column = 0;
      at_odd_row = 1'b0;
      foreach (line_filled[i]) line_filled[i] = 1'b0;

      // Synchronous reset held high, then released.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frame at the narrowest width.
      write_frame_width(12'd2);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_pixel(DIRECTED_SOF[i], DIRECTED_RGB[i][23:16], DIRECTED_RGB[i][15:8],
                    DIRECTED_RGB[i][7:0]);
      end

      // Random phases. Frames are mostly continuous raster; a rare random
      // start-of-frame marker restarts the raster mid-row. Phases four and
      // five run without any idle cycles on either side.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_frame_width(PHASE_WIDTHS[p]);
         steady <= (p == 4 || p == 5);
         count = $urandom_range(100, 60);
         for (int n = 0; n < count; n++) begin
            send_pixel(($urandom_range(149) == 0), pick_component(), pick_component(),
                       pick_component());
         end
      end

      // Drain: wait for every expected word, then a little longer so that
      // any stray extra word would still be seen.
      req_valid <= 1'b0;
      steady <= 1'b0;
      @(posedge clock);
      drain = 0;
      while (outstanding != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (16) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** rgb_to_ycbcr420_converter: PASSED **");
      end else begin
         $display("** rgb_to_ycbcr420_converter: FAILED **");
      end
      $finish;
   end

endmodule

// ===== rgb_to_ycbcr420_converter.f =====
rtl/rgb2ycc_pkg.sv
rtl/rgb2ycc_line_mem.sv
rtl/rgb_to_ycbcr420_converter.sv
tb/sv/ycc420_checker.sv
tb/sv/testbench.sv
